FILE: rtl/frg_pkg.sv
// ----------------------------------------------------------------------------
// frg_pkg
// Shared constants for the fraction reduce block: default operand width.
// ----------------------------------------------------------------------------
package frg_pkg;

  // Default width of every value field (numerator, denominator, divisor).
  localparam int VALUE_WIDTH_DEF = 31;

endpackage : frg_pkg

FILE: rtl/frg_divider.sv
// ----------------------------------------------------------------------------
// frg_divider
// Restoring radix-2 divider: one quotient bit a cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module frg_divider #(
  parameter int VALUE_WIDTH = frg_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);
  import frg_pkg::*;

  localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [CW-1:0]          cnt;

  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  // Shift in the next dividend bit, trial-subtract the divisor.
  always_comb begin
    rem_sh = {rem, quo[VALUE_WIDTH-1]};
    ge     = (rem_sh >= {1'b0, dvs});
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(VALUE_WIDTH - 1);
    end else if (busy) begin
      rem <= ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
      quo <= {quo[VALUE_WIDTH-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule : frg_divider

FILE: rtl/fraction_reduce_gcd_unit.sv
// ----------------------------------------------------------------------------
// fraction_reduce_gcd_unit
// Reduces numerator/denominator to lowest terms with a Euclid gcd search.
// ----------------------------------------------------------------------------
// One word in, one word out. The gcd is found by the modulo form of Euclid's
// algorithm: while both working values are nonzero, the larger is replaced
// by its remainder modulo the smaller (on a tie the denominator side is
// reduced). Then numerator and denominator are divided by the gcd. All of
// this runs on a single restoring divider that yields one quotient bit per
// cycle. The number k of Euclid steps is data dependent (at most about 45
// for 31-bit values, typically a handful). s_tready is high only while the
// sequencer is idle. A finished word sits in an output register, so a new
// item may enter while the previous result still waits on m_tready. If both
// inputs are zero the gcd is zero: zero_error is raised, the divisor field
// is zero and the inputs are passed through unchanged.
// ----------------------------------------------------------------------------
module fraction_reduce_gcd_unit #(
  parameter int VALUE_WIDTH = frg_pkg::VALUE_WIDTH_DEF,
  localparam int IN_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // slave side
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // numerator, denominator, zero pad
  // master side
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // reduced_numerator, reduced_denominator,
                                      // common_divisor, zero pad
  output logic             m_tuser    // zero_error
);
  import frg_pkg::*;

  localparam int W = VALUE_WIDTH;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_DIVN  = 6'b001000,
    ST_DIVD  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Working registers.
  logic [W-1:0] n, d;        // original inputs
  logic [W-1:0] x, y;        // Euclid working pair
  logic [W-1:0] g;           // gcd
  logic [W-1:0] qn, qd;      // reduced values
  logic         err;
  logic         sel_x;       // the pending remainder replaces x

  // Output register.
  logic [W-1:0] out_n, out_d, out_g;
  logic         out_err;

  // Shared divider hookup.
  logic         div_start;
  logic [W-1:0] div_a, div_b;
  logic         div_busy, div_done;
  logic [W-1:0] div_q, div_r;

  logic         pair_done;
  logic         x_gt_y;
  logic         out_free;

  assign pair_done = (x == '0) || (y == '0);
  assign x_gt_y    = (x > y);
  assign out_free  = !m_tvalid || m_tready;

  frg_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequencer: choose the next state and what the divider works on.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = n;
    div_b      = g;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pair_done) begin
          // gcd is x|y here; zero gcd skips the divisions
          if ((x | y) == '0) begin
            state_next = ST_DONE;
          end else begin
            div_start  = 1'b1;
            div_a      = n;
            div_b      = x | y;
            state_next = ST_DIVN;
          end
        end else begin
          div_start  = 1'b1;
          div_a      = x_gt_y ? x : y;
          div_b      = x_gt_y ? y : x;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = d;
          div_b      = g;
          state_next = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          n <= s_tdata[W-1:0];
          d <= s_tdata[2*W-1:W];
          x <= s_tdata[W-1:0];
          y <= s_tdata[2*W-1:W];
        end
      end
      ST_CHECK: begin
        sel_x <= x_gt_y;
        if (pair_done) begin
          g   <= x | y;
          err <= ((x | y) == '0);
          // pass inputs through on error; overwritten by the divisions otherwise
          qn  <= n;
          qd  <= d;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          if (sel_x) begin
            x <= div_r;
          end else begin
            y <= div_r;
          end
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          qn <= div_q;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          qd <= div_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Output word register: load on leaving DONE, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_n   <= qn;
      out_d   <= qd;
      out_g   <= g;
      out_err <= err;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = OUT_W'({out_g, out_d, out_n});
  assign m_tuser  = out_err;

`ifndef SYNTHESIS
  // The divider is never left running while a new item may enter.
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("divider busy while accepting input");

  // A modulo step always returns to the zero check.
  a_mod_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) && div_done |=> (state == ST_CHECK))
    else $error("modulo step did not return to check");

  // An error word carries a zero divisor, a normal word a nonzero one.
  a_err_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_err == (out_g == '0)))
    else $error("zero_error and divisor disagree");

  // A divider is only started when idle or just finishing.
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!div_busy || div_done))
    else $error("divider restarted while busy");

  // The output word is loaded only when the register is free.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !out_free |=> (state == ST_DONE))
    else $error("result left DONE while output held");
`endif

endmodule : fraction_reduce_gcd_unit
